// ===== sv/pbbf_pkg.sv =====
// Package for the partitioned blocked Bloom filter.
// Holds sizing defaults, mixer constants, register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
package pbbf_pkg;
	localparam int MAX_BLOCKS_DEF      = 1024;
	localparam int MAX_BLOCK_WORDS_DEF = 16;
	localparam int MAX_PROBES_DEF      = 64;

	// Register reset values
	localparam logic [10:0] NUM_BLOCKS_RST  = 11'd1024;
	localparam logic [4:0]  BLOCK_WORDS_RST = 5'd8;
	localparam logic [6:0]  NUM_PROBES_RST  = 7'd8;

	// Probe mixer constants
	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int MIX_SHIFT = 33;

	localparam int DIV_STEPS = 10;

	typedef enum logic [1:0] {
		REG_NUM_BLOCKS  = 2'd0,
		REG_BLOCK_WORDS = 2'd1,
		REG_NUM_PROBES  = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DIV, S_BLK, S_BASE,
		S_MA, S_MB, S_MC, S_MD, S_OFF, S_RD, S_UP
	} seq_state_t;

	// Fold the top 31 bits of a word (bits 63:33) into its low bits
	function automatic logic [63:0] fold33(input logic [63:0] v);
		return v ^ (v >> MIX_SHIFT);
	endfunction
endpackage

// ===== sv/partitioned_blocked_bloom_filter.sv =====
// Requests are taken one at a time: in_stall stays high from an accepted request until its
// last probe is done. A 10-step divider runs first; then the shared 32x32 multiplier and
// the table are stepped through each probe in use.
// Reset: registers return to defaults and a clearing pass writes the table to zero,
// one word a cycle, before input opens.
`timescale 1ns / 1ps
module partitioned_blocked_bloom_filter #(
	parameter int MAX_BLOCKS      = pbbf_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_BLOCK_WORDS = pbbf_pkg::MAX_BLOCK_WORDS_DEF,
	parameter int MAX_PROBES      = pbbf_pkg::MAX_PROBES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [63:0] key_digest,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        present,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import pbbf_pkg::*;

	localparam int TW = MAX_BLOCKS * MAX_BLOCK_WORDS;
	localparam int AW = (TW > 1) ? $clog2(TW) : 1;

	logic [31:0] mem [TW];
	logic [31:0] rdata_q;

	seq_state_t state_q, state_d;

	logic [10:0] num_blocks_q;
	logic [4:0]  block_words_q;
	logic [6:0]  num_probes_q;

	logic        op_q, hit_q, pass_q;
	logic [63:0] x_q, xm_q, acc_q, prod_q;
	logic [9:0]  div_q, start_q, size_q;
	logic [6:0]  r_q, rem_q, nrem_q, i_q;
	logic [3:0]  dcnt_q;
	logic [AW-1:0] base_q, addr_q, clr_q;
	logic [4:0]  bit_q;
	logic        out_valid_q, present_q;

	// Saturated register values
	logic [31:0] nb_raw, nb_c;
	logic [4:0]  bw_c;
	logic [6:0]  k_c;
	logic [9:0]  bits;
	always_comb begin
		nb_raw = 32'(num_blocks_q);
		if (nb_raw == 32'd0)
			nb_c = 32'd1;
		else if (nb_raw > 32'(MAX_BLOCKS))
			nb_c = 32'(MAX_BLOCKS);
		else
			nb_c = nb_raw;
		if (block_words_q == 5'd0)
			bw_c = 5'd1;
		else if (32'(block_words_q) > 32'(MAX_BLOCK_WORDS))
			bw_c = 5'(MAX_BLOCK_WORDS);
		else
			bw_c = block_words_q;
		if (num_probes_q == 7'd0)
			k_c = 7'd1;
		else if (32'(num_probes_q) > 32'(MAX_PROBES))
			k_c = 7'(MAX_PROBES);
		else
			k_c = num_probes_q;
		bits = {bw_c, 5'd0};
	end

	// Divider step, partition size and probe address
	logic [7:0]  dtry;
	logic        dge;
	logic [7:0]  rsum;
	logic        rcy;
	logic [9:0]  size_d;
	logic [9:0]  pos;
	logic [AW-1:0] raddr;
	logic [63:0] full, nx;
	logic        last;
	always_comb begin
		dtry = {r_q, div_q[9]};
		dge = dtry >= {1'b0, k_c};
		rsum = {1'b0, rem_q} + {1'b0, r_q};
		rcy = rsum >= {1'b0, k_c};
		size_d = div_q + 10'(rcy);
		pos = start_q + prod_q[41:32];
		raddr = base_q + AW'(pos[9:5]);
		full = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
		nx = x_q + GOLDEN;
		last = i_q == k_c - 7'd1;
	end

	// Shared multiplier operand select
	logic [31:0] mul_a, mul_b;
	logic [63:0] mconst;
	always_comb begin
		mconst = pass_q ? MIX_C2 : MIX_C1;
		mul_a = xm_q[31:0];
		mul_b = mconst[31:0];
		case (state_q)
			S_BLK: begin
				mul_a = x_q[63:32];
				mul_b = nb_c;
			end
			S_BASE: begin
				mul_a = prod_q[63:32];
				mul_b = 32'(bw_c);
			end
			S_MB: begin
				mul_a = xm_q[63:32];
				mul_b = mconst[31:0];
			end
			S_MC: begin
				mul_a = xm_q[31:0];
				mul_b = mconst[63:32];
			end
			S_OFF: begin
				mul_a = xm_q[63:32];
				mul_b = 32'(size_d);
			end
			default: begin
				mul_a = xm_q[31:0];
				mul_b = mconst[31:0];
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR:  if (clr_q == AW'(TW - 1)) state_d = S_IDLE;
			S_IDLE: if (in_valid) state_d = S_DIV;
			S_DIV:  if (dcnt_q == 4'(DIV_STEPS - 1)) state_d = S_BLK;
			S_BLK:  state_d = S_BASE;
			S_BASE: state_d = S_MA;
			S_MA:   state_d = S_MB;
			S_MB:   state_d = S_MC;
			S_MC:   state_d = S_MD;
			S_MD:   state_d = pass_q ? S_OFF : S_MA;
			S_OFF:  state_d = S_RD;
			S_RD:   state_d = S_UP;
			S_UP: begin
				if (!last)
					state_d = S_MA;
				else if (!(op_q && out_valid_q && out_stall))
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLR;
		else
			state_q <= state_d;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q  <= NUM_BLOCKS_RST;
			block_words_q <= BLOCK_WORDS_RST;
			num_probes_q  <= NUM_PROBES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NUM_BLOCKS:  num_blocks_q  <= cfg_data;
				REG_BLOCK_WORDS: block_words_q <= cfg_data[4:0];
				REG_NUM_PROBES:  num_probes_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Clear counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLR)
				clr_q <= clr_q + AW'(1);
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (state_q == S_UP && last && op_q && !(out_valid_q && out_stall))
				out_valid_q <= 1'b1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				op_q   <= operation;
				x_q    <= key_digest;
				xm_q   <= fold33(key_digest);
				div_q  <= bits;
				r_q    <= '0;
				dcnt_q <= '0;
				pass_q <= 1'b0;
				hit_q  <= 1'b1;
				i_q    <= '0;
				start_q <= '0;
				rem_q  <= '0;
			end
			S_DIV: begin
				div_q  <= {div_q[8:0], dge};
				r_q    <= dge ? 7'(dtry - {1'b0, k_c}) : dtry[6:0];
				dcnt_q <= dcnt_q + 4'd1;
			end
			S_MA: if (i_q == 7'd0 && !pass_q) base_q <= prod_q[AW-1:0];
			S_MB: acc_q <= prod_q;
			S_MC: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
			S_MD: begin
				xm_q   <= fold33(full);
				pass_q <= ~pass_q;
			end
			S_OFF: begin
				size_q <= size_d;
				nrem_q <= rcy ? 7'(rsum - {1'b0, k_c}) : rsum[6:0];
			end
			S_RD: begin
				addr_q <= raddr;
				bit_q  <= pos[4:0];
			end
			S_UP: begin
				if (!rdata_q[bit_q])
					hit_q <= 1'b0;
				if (last) begin
					// hold the waiting answer until it is taken
					if (!(out_valid_q && out_stall))
						present_q <= hit_q & rdata_q[bit_q];
				end else begin
					i_q     <= i_q + 7'd1;
					start_q <= start_q + size_q;
					rem_q   <= nrem_q;
					x_q     <= nx;
					xm_q    <= fold33(nx);
				end
			end
			default: ;
		endcase
	end

	// Table memory: clear pass, probe writes, registered read
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	always_comb begin
		we = (state_q == S_CLR) || (state_q == S_UP && !op_q);
		waddr = (state_q == S_CLR) ? clr_q : addr_q;
		wdata = (state_q == S_CLR) ? 32'd0 : (rdata_q | (32'd1 << bit_q));
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (state_q == S_RD)
			rdata_q <= mem[raddr];
	end

	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign present   = present_q;

`ifndef SYNTHESIS
	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_DIV)
		else $error("accepted request did not start the divider");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OFF |-> rem_q < k_c && r_q < k_c)
		else $error("partition remainder out of range");
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> size_q == 10'd0 || prod_q[63:32] < 32'(size_q))
		else $error("probe offset beyond its partition");
	a_out_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(op_q))
		else $error("result raised for an insert");
`endif
endmodule
